>>> design/sfv_pkg.sv
// Shared constants and types of the sensor faucet valve control.
`default_nettype none

package sfv_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned RunW     = 16;
  localparam int unsigned WetW     = 10;
  localparam int unsigned PauseW   = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SampleW-1:0] WindowHalf    = 10'd20;
  localparam logic [SampleW-1:0] ReleaseMargin = 10'd50;
  localparam logic [WetW-1:0]    WetLimit      = 10'd1000;
  localparam logic [PauseW-1:0]  PauseLength   = 13'd5000;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegPresenceA = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPresenceB = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWaterA    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWaterB    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWarm      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRunLimit  = 3'd5;

  typedef struct packed {
    logic [SampleW-1:0] presence_level_a;
    logic [SampleW-1:0] presence_level_b;
    logic [SampleW-1:0] water_level_a;
    logic [SampleW-1:0] water_level_b;
    logic [SampleW-1:0] warm_level;
    logic [RunW-1:0]    run_limit;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_a;
    logic [SampleW-1:0] sample_b;
    logic [SampleW-1:0] sample_temp;
    logic               tick;
  } pass_in_t;

  typedef struct packed {
    logic hot_valve;
    logic cold_valve;
    logic session_active;
    logic pausing;
  } pass_out_t;

  typedef struct packed {
    logic              active_flag;
    logic              hot_open;
    logic              cold_open;
    logic [RunW-1:0]   run_left;
    logic [WetW-1:0]   wet_count;
    logic [PauseW-1:0] pause_left;
  } ctl_state_t;

endpackage

`default_nettype wire

>>> design/sfv_cfg_regs.sv
// Configuration register file of the sensor faucet valve control.
`default_nettype none

module sfv_cfg_regs
  import sfv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        RegPresenceA: cfg_d.presence_level_a = wr_data_i[SampleW-1:0];
        RegPresenceB: cfg_d.presence_level_b = wr_data_i[SampleW-1:0];
        RegWaterA:    cfg_d.water_level_a    = wr_data_i[SampleW-1:0];
        RegWaterB:    cfg_d.water_level_b    = wr_data_i[SampleW-1:0];
        RegWarm:      cfg_d.warm_level       = wr_data_i[SampleW-1:0];
        RegRunLimit:  cfg_d.run_limit        = wr_data_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.presence_level_a <= 10'd512;
      cfg_q.presence_level_b <= 10'd512;
      cfg_q.water_level_a    <= 10'd300;
      cfg_q.water_level_b    <= 10'd300;
      cfg_q.warm_level       <= 10'd600;
      cfg_q.run_limit        <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/sfv_ctl_core.sv
// Control state and the single-pass update logic of the faucet controller.
`default_nettype none

module sfv_ctl_core
  import sfv_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire cfg_t     cfg_i,
  input  wire pass_in_t pass_i,
  output pass_out_t     pass_o,
  output ctl_state_t    state_o
);

  ctl_state_t st_q, st_d;

  logic [RunW-1:0]   run_dec;
  logic [PauseW-1:0] pause_dec;
  logic [WetW-1:0]   wet_new;
  logic              win_a, win_b, presence, release_ok, wet_over;

  // Sums are taken one bit wider so the window and margin compares are exact.
  always_comb begin
    win_a = ({1'b0, pass_i.sample_a} + {1'b0, WindowHalf} > {1'b0, cfg_i.water_level_a}) &&
            ({1'b0, pass_i.sample_a} < {1'b0, cfg_i.water_level_a} + {1'b0, WindowHalf});
    win_b = ({1'b0, pass_i.sample_b} + {1'b0, WindowHalf} > {1'b0, cfg_i.water_level_b}) &&
            ({1'b0, pass_i.sample_b} < {1'b0, cfg_i.water_level_b} + {1'b0, WindowHalf});

    run_dec   = (pass_i.tick && st_q.run_left != '0) ? st_q.run_left - 1'b1 : st_q.run_left;
    pause_dec = (st_q.pause_left != '0) ? st_q.pause_left - 1'b1 : st_q.pause_left;

    if (win_a && win_b) begin
      wet_new = (st_q.wet_count <= WetLimit) ? st_q.wet_count + 1'b1 : st_q.wet_count;
    end else begin
      wet_new = '0;
    end
    wet_over = wet_new > WetLimit;

    presence = ((pass_i.sample_a > cfg_i.presence_level_a) ||
                (pass_i.sample_b > cfg_i.presence_level_b)) && (pause_dec == '0);
    release_ok = (({1'b0, pass_i.sample_a} + {1'b0, ReleaseMargin}
                   < {1'b0, cfg_i.presence_level_a}) &&
                  ({1'b0, pass_i.sample_b} + {1'b0, ReleaseMargin}
                   < {1'b0, cfg_i.presence_level_b})) || wet_over;

    st_d            = st_q;
    st_d.run_left   = run_dec;
    st_d.pause_left = pause_dec;
    st_d.wet_count  = wet_new;

    if (presence) begin
      if (st_q.active_flag && run_dec == '0) begin
        // Session timed out: valves stay forced off until hands leave.
        st_d.hot_open  = 1'b0;
        st_d.cold_open = 1'b0;
      end else begin
        if (!st_q.active_flag) begin
          st_d.active_flag = 1'b1;
          st_d.run_left    = cfg_i.run_limit;
        end
        st_d.hot_open = 1'b1;
        if (pass_i.sample_temp > cfg_i.warm_level) begin
          st_d.cold_open = 1'b1;
        end
      end
    end else if (release_ok) begin
      if (wet_over) begin
        st_d.pause_left = PauseLength;
      end
      st_d.hot_open    = 1'b0;
      st_d.cold_open   = 1'b0;
      st_d.active_flag = 1'b0;
      st_d.run_left    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign pass_o.hot_valve      = st_d.hot_open;
  assign pass_o.cold_valve     = st_d.cold_open;
  assign pass_o.session_active = st_d.active_flag;
  assign pass_o.pausing        = st_d.pause_left != '0;
  assign state_o               = st_q;

endmodule

`default_nettype wire

>>> design/sensor_faucet_valve_control.sv
// Sensor faucet valve control: top level with input and result registers.
// Accepted words go to the input register, their pass results to the result register.
// Throughput: one word per cycle unless m_axis_tready stalls; the pass is compares and counters.
// Reset: rst_ni is asynchronous, active low; state clears, config registers return to defaults.
// The configuration port is always ready and takes one register write per cycle.
`default_nettype none

module sensor_faucet_valve_control
  import sfv_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [9:0] sample_a, [19:10] sample_b, [29:20] sample_temp, [30] tick, [31] zero
  input  wire logic [31:0]         s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] hot_valve, [1] cold_valve, [2] session_active, [3] pausing, [7:4] zero
  output logic [7:0]               m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t       cfg;
  pass_in_t   in_q;
  pass_out_t  res, out_q;
  ctl_state_t state;
  logic       in_v_q, out_v_q;
  logic       advance, accept;

  assign cfg_ready_o = 1'b1;

  sfv_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // The held word runs its pass when the result register is free or draining.
  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfv_ctl_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .cfg_i   (cfg),
    .pass_i  (in_q),
    .pass_o  (res),
    .state_o (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.sample_a    <= s_axis_tdata[9:0];
      in_q.sample_b    <= s_axis_tdata[19:10];
      in_q.sample_temp <= s_axis_tdata[29:20];
      in_q.tick        <= s_axis_tdata[30];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0000, out_q.pausing, out_q.session_active,
                          out_q.cold_valve, out_q.hot_valve};

  // A running pause always leaves both valves shut.
  a_pause_shut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state.pause_left != '0) |-> (!state.hot_open && !state.cold_open))
    else $error("valve open during pause");

  // The cold valve only ever opens together with the hot one.
  a_cold_with_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.cold_open |-> state.hot_open)
    else $error("cold valve open without hot valve");

  // An open valve implies a running session.
  a_hot_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.hot_open |-> state.active_flag)
    else $error("hot valve open without session");

  // The water pass counter saturates just above its limit.
  a_wet_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state.wet_count <= WetLimit + 10'd1)
    else $error("water pass counter beyond saturation");

  // A word that runs its pass shows up as a result in the next cycle.
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("result word lost after pass");

endmodule

`default_nettype wire

>>> verif/tb_sensor_faucet_valve_control.sv
// Self-checking testbench of the sensor faucet valve control with its own valve predictor.
`timescale 1ns / 100ps

module tb_sensor_faucet_valve_control;
  import sfv_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int WetHalf     = 20;
  localparam int ReleaseGap  = 50;
  localparam int WetMax      = 1000;
  localparam int PauseSpan   = 5000;
  localparam int NumProbes   = 16;
  localparam int HoldAfter   = 500;
  localparam int HoldCycles  = 300;

  // Writes to these indexes must leave every register untouched.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef enum int {SceneHand, SceneLeave, SceneHover, SceneWet, SceneNoise} scene_e;

  typedef struct packed {
    logic [SampleW-1:0] sa;
    logic [SampleW-1:0] sb;
    logic [SampleW-1:0] st;
    logic               tk;
    logic               known;
    logic               hot;
    logic               cold;
    logic               act;
    logic               pse;
  } probe_t;

  // Rows run right after reset with the default register values.
  localparam probe_t ProbeRows [NumProbes] = '{
    '{10'd0,    10'd0,    10'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{10'd1023, 10'd0,    10'd1023, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{10'd0,    10'd0,    10'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{10'd0,    10'd1023, 10'd600,  1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
    '{10'd513,  10'd513,  10'd601,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{10'd512,  10'd512,  10'd0,    1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{10'd462,  10'd0,    10'd0,    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{10'd0,    10'd462,  10'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{10'd461,  10'd461,  10'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{10'd281,  10'd319,  10'd0,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{10'd280,  10'd320,  10'd0,    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{10'd300,  10'd300,  10'd1023, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{10'd1023, 10'd1023, 10'd0,    1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
    '{10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
    '{10'd700,  10'd0,    10'd0,    1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cfg_t       valve_cfg;
  ctl_state_t valve_state;
  pass_out_t  valve_expect_q [$];

  int mismatch_cnt = 0;
  int words_out    = 0;
  int passes_sent  = 0;
  int burst_left   = 0;
  int tick_pct     = 30;

  sensor_faucet_valve_control uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // One control pass of the valve logic on the predictor's own state.
  function automatic pass_out_t predict_valves(input pass_in_t p);
    int        sa;
    int        sb;
    bit        wet;
    bit        hand;
    pass_out_t r;
    sa = int'(p.sample_a);
    sb = int'(p.sample_b);
    if (p.tick && valve_state.run_left != 0) valve_state.run_left--;
    if (valve_state.pause_left != 0) valve_state.pause_left--;
    wet = (sa + WetHalf > int'(valve_cfg.water_level_a)) &&
          (sa < int'(valve_cfg.water_level_a) + WetHalf) &&
          (sb + WetHalf > int'(valve_cfg.water_level_b)) &&
          (sb < int'(valve_cfg.water_level_b) + WetHalf);
    if (wet) begin
      if (valve_state.wet_count <= WetMax) valve_state.wet_count++;
    end else begin
      valve_state.wet_count = '0;
    end
    hand = (sa > int'(valve_cfg.presence_level_a)) || (sb > int'(valve_cfg.presence_level_b));
    if (hand && valve_state.pause_left == 0) begin
      if (valve_state.active_flag && valve_state.run_left == 0) begin
        // Session ran out of time: valves stay shut until the hands go away.
        valve_state.hot_open  = 1'b0;
        valve_state.cold_open = 1'b0;
      end else begin
        if (!valve_state.active_flag) begin
          valve_state.active_flag = 1'b1;
          valve_state.run_left    = valve_cfg.run_limit;
        end
        valve_state.hot_open = 1'b1;
        if (p.sample_temp > valve_cfg.warm_level) valve_state.cold_open = 1'b1;
      end
    end else if ((sa + ReleaseGap < int'(valve_cfg.presence_level_a) &&
                  sb + ReleaseGap < int'(valve_cfg.presence_level_b)) ||
                 valve_state.wet_count > WetMax) begin
      if (valve_state.wet_count > WetMax) valve_state.pause_left = PauseW'(PauseSpan);
      valve_state.hot_open    = 1'b0;
      valve_state.cold_open   = 1'b0;
      valve_state.active_flag = 1'b0;
      valve_state.run_left    = '0;
    end
    r.hot_valve      = valve_state.hot_open;
    r.cold_valve     = valve_state.cold_open;
    r.session_active = valve_state.active_flag;
    r.pausing        = (valve_state.pause_left != 0);
    return r;
  endfunction

  function automatic pass_in_t make_pass(input scene_e kind);
    pass_in_t p;
    int       pa;
    int       pb;
    int       lo;
    int       hi;
    pa = int'(valve_cfg.presence_level_a);
    pb = int'(valve_cfg.presence_level_b);
    p.sample_a    = SampleW'($urandom);
    p.sample_b    = SampleW'($urandom);
    p.sample_temp = SampleW'($urandom);
    p.tick        = ($urandom_range(0, 99) < tick_pct);
    case (kind)
      SceneHand: begin
        if (pa < 1023 && (pb >= 1023 || $urandom_range(0, 1) == 1)) begin
          p.sample_a = SampleW'($urandom_range(1023, pa + 1));
        end else if (pb < 1023) begin
          p.sample_b = SampleW'($urandom_range(1023, pb + 1));
        end
      end
      SceneLeave: begin
        if (pa > ReleaseGap) p.sample_a = SampleW'($urandom_range(pa - ReleaseGap - 1, 0));
        if (pb > ReleaseGap) p.sample_b = SampleW'($urandom_range(pb - ReleaseGap - 1, 0));
      end
      SceneHover: begin
        p.sample_a = SampleW'($urandom_range(pa, (pa > ReleaseGap) ? pa - ReleaseGap : 0));
        p.sample_b = SampleW'($urandom_range(pb, (pb > ReleaseGap) ? pb - ReleaseGap : 0));
      end
      SceneWet: begin
        lo = int'(valve_cfg.water_level_a) - WetHalf + 1;
        hi = int'(valve_cfg.water_level_a) + WetHalf - 1;
        p.sample_a = SampleW'($urandom_range((hi > 1023) ? 1023 : hi, (lo < 0) ? 0 : lo));
        lo = int'(valve_cfg.water_level_b) - WetHalf + 1;
        hi = int'(valve_cfg.water_level_b) + WetHalf - 1;
        p.sample_b = SampleW'($urandom_range((hi > 1023) ? 1023 : hi, (lo < 0) ? 0 : lo));
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic report_mismatch(input string what, input pass_out_t want,
                                 input logic [7:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s: expected hot %b cold %b active %b pausing %b, got tdata %b",
               $time, what, want.hot_valve, want.cold_valve, want.session_active,
               want.pausing, got);
    end
  endtask

  // Offers one input word in bursts with random gaps and records what it must cause.
  task automatic offer_pass(input pass_in_t p, input bit preset = 1'b0,
                            input pass_out_t preset_out = '0);
    int        gap;
    pass_out_t want;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, p.tick, p.sample_temp, p.sample_b, p.sample_a};
    do @(posedge clk_i); while (!s_axis_tready);
    passes_sent++;
    want = predict_valves(p);
    valve_expect_q.push_back(preset ? preset_out : want);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (valve_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves valid high so that back-to-back writes need no second assignment per step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegPresenceA: valve_cfg.presence_level_a = data[SampleW-1:0];
      RegPresenceB: valve_cfg.presence_level_b = data[SampleW-1:0];
      RegWaterA:    valve_cfg.water_level_a    = data[SampleW-1:0];
      RegWaterB:    valve_cfg.water_level_b    = data[SampleW-1:0];
      RegWarm:      valve_cfg.warm_level       = data[SampleW-1:0];
      RegRunLimit:  valve_cfg.run_limit        = data[RunW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CfgDataW-1:0] pa, input logic [CfgDataW-1:0] pb,
                              input logic [CfgDataW-1:0] wa, input logic [CfgDataW-1:0] wb,
                              input logic [CfgDataW-1:0] warm,
                              input logic [CfgDataW-1:0] run_lim);
    write_reg(RegPresenceA, pa);
    write_reg(RegPresenceB, pb);
    write_reg(RegWaterA, wa);
    write_reg(RegWaterB, wb);
    write_reg(RegWarm, warm);
    write_reg(RegRunLimit, run_lim);
    write_reg(($urandom_range(0, 1) == 1) ? RegSpareHi : RegSpareLo, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly whole hand sessions, with short wet runs, hovering and noise between them.
  task automatic run_scenes(input int n);
    int stop;
    int pick;
    int k;
    int i;
    stop = passes_sent + n;
    while (passes_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        k = $urandom_range(1, 40);
        for (i = 0; i < k; i++) offer_pass(make_pass(SceneHand));
        k = $urandom_range(0, 10);
        for (i = 0; i < k; i++) offer_pass(make_pass(SceneHover));
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) offer_pass(make_pass(SceneLeave));
      end else if (pick < 65) begin
        k = $urandom_range(1, 30);
        for (i = 0; i < k; i++) offer_pass(make_pass(SceneWet));
      end else if (pick < 80) begin
        k = $urandom_range(1, 10);
        for (i = 0; i < k; i++) offer_pass(make_pass(SceneHover));
      end else begin
        k = $urandom_range(1, 10);
        for (i = 0; i < k; i++) offer_pass(make_pass(SceneNoise));
      end
    end
  endtask

  // Receiver: changing stall patterns, and once a long hold-off that backs up the input.
  initial begin : sink_pacer
    int mode;
    int mode_left;
    int hold_left;
    bit held;
    m_axis_tready = 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held && words_out >= HoldAfter) begin
        held      = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : valve_word_check
    pass_out_t seen;
    pass_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.hot_valve      = m_axis_tdata[0];
      seen.cold_valve     = m_axis_tdata[1];
      seen.session_active = m_axis_tdata[2];
      seen.pausing        = m_axis_tdata[3];
      if (valve_expect_q.size() == 0) begin
        report_mismatch("valve word with nothing pending", '0, m_axis_tdata);
      end else begin
        want = valve_expect_q.pop_front();
        if (seen !== want || m_axis_tdata[7:4] !== 4'd0) begin
          report_mismatch("valve word differs", want, m_axis_tdata);
        end
      end
      words_out++;
    end
  end

  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    pass_in_t  p;
    pass_out_t want;
    int        i;
    int        wet_len;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    valve_cfg     = '{10'd512, 10'd512, 10'd300, 10'd300, 10'd600, 16'd1000};
    valve_state   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NumProbes; i++) begin
      p.sample_a    = ProbeRows[i].sa;
      p.sample_b    = ProbeRows[i].sb;
      p.sample_temp = ProbeRows[i].st;
      p.tick        = ProbeRows[i].tk;
      want.hot_valve      = ProbeRows[i].hot;
      want.cold_valve     = ProbeRows[i].cold;
      want.session_active = ProbeRows[i].act;
      want.pausing        = ProbeRows[i].pse;
      offer_pass(p, ProbeRows[i].known, want);
    end
    run_scenes(80);

    // Extreme levels, A low and B high; a zero run limit forces the valves shut on every hand pass
    // after the first one of a session.
    drain_results();
    program_regs(16'd50, 16'd1023, 16'd20, 16'd1003, 16'd0, 16'd0);
    tick_pct = 50;
    run_scenes(80);

    drain_results();
    program_regs(16'd1023, 16'd50, 16'd1003, 16'd20, 16'd1023, 16'hFFFF);
    run_scenes(80);

    // Raw 16-bit data: upper bits of the 10-bit registers must be dropped.
    drain_results();
    program_regs(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
                 CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom));
    tick_pct = 40;
    run_scenes(80);

    drain_results();
    program_regs(CfgDataW'($urandom_range(50, 1023)), CfgDataW'($urandom_range(50, 1023)),
                 CfgDataW'($urandom_range(20, 1003)), CfgDataW'($urandom_range(20, 1003)),
                 CfgDataW'($urandom_range(0, 1023)), CfgDataW'($urandom_range(1, 30)));
    tick_pct = 60;
    run_scenes(80);

    // Both water windows sit just under the presence levels, so a session opened
    // before the wet run is rarely released by it; the wet count limit then shuts
    // the valves and starts the pause.
    drain_results();
    program_regs(16'd512, 16'd512, 16'd480, 16'd470, CfgDataW'($urandom_range(0, 1023)),
                 16'd2000);
    tick_pct = 5;
    for (i = 0; i < 5; i++) offer_pass(make_pass(SceneHand));
    wet_len = WetMax + 1 + $urandom_range(5, 40);
    for (i = 0; i < wet_len; i++) offer_pass(make_pass(SceneWet));
    tick_pct = 40;
    run_scenes(80);

    drain_results();
    program_regs(CfgDataW'($urandom_range(50, 1023)), CfgDataW'($urandom_range(50, 1023)),
                 CfgDataW'($urandom_range(20, 1003)), CfgDataW'($urandom_range(20, 1003)),
                 CfgDataW'($urandom_range(0, 1023)), CfgDataW'($urandom_range(0, 200)));
    run_scenes(80);

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sfv_pkg.sv
design/sfv_cfg_regs.sv
design/sfv_ctl_core.sv
design/sensor_faucet_valve_control.sv
verif/tb_sensor_faucet_valve_control.sv
